### design/rts_pkg.sv
`timescale 1ns / 1ps

package rts_pkg;

   localparam int POS_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int GRP_BITS    = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h0D;
   localparam logic [BYTE_W-1:0] BLANK      = 8'h20;
   localparam logic [BYTE_W-1:0] NUL        = 8'h00;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] char_byte;
   } cmd_type;

endpackage

### design/rts_front.sv
`timescale 1ns / 1ps

module rts_front (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [13:0]              req_tdata,     // position, char_byte
   input  logic                     req_tuser,     // operation
   input  logic [rts_pkg::LEN_W-1:0] string_length,
   output logic                     push_valid,
   input  logic                     push_ready,
   output rts_pkg::cmd_type         push_cmd
);
   import rts_pkg::*;

   logic in_range;

   always_comb begin
      push_cmd.kind      = kind_type'(req_tuser);
      push_cmd.position  = req_tdata[POS_W-1:0];
      push_cmd.char_byte = req_tdata[POS_W +: BYTE_W];
   end

   // writes at or beyond the length are dropped here
   assign in_range   = {1'b0, push_cmd.position} < string_length;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid && (push_cmd.kind == KIND_CLEAR || in_range);

endmodule

### design/rts_queue.sv
`timescale 1ns / 1ps

module rts_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rts_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output rts_pkg::cmd_type out_cmd
);
   import rts_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != FULL;
   assign out_valid = count_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/rts_back.sv
`timescale 1ns / 1ps

module rts_back #(
   parameter int USABLE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [rts_pkg::LEN_W-1:0] csr_wdata,
   output logic [rts_pkg::LEN_W-1:0] string_length,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  rts_pkg::cmd_type          cmd,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // out_index, out_byte
   output logic                      rsp_tlast    // last
);
   import rts_pkg::*;

   localparam int IDX_W = $clog2(USABLE);
   localparam int NGRP  = (USABLE + GRP_BITS - 1) / GRP_BITS;
   localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int NTERM = NGRP * GRP_BITS;
   localparam int SEL_W = $clog2(GRP_BITS);
   localparam logic [LEN_W-1:0] USABLE_LEN = LEN_W'(USABLE);
   localparam logic [GRP_W-1:0] LAST_GRP   = GRP_W'(NGRP - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  recv_ff;
   logic [POS_W-1:0]  prev_ff;
   logic [GRP_W-1:0]  grp_ff;
   logic [LEN_W-1:0]  exp_ff;
   logic [IDX_W-1:0]  k_ff;
   logic [USABLE-1:0] valid_ff;
   logic [NTERM-1:0]  term_ff;
   logic [BYTE_W-1:0] mem [USABLE];
   logic [BYTE_W-1:0] rd_data_ff;

   logic              pop, mem_we;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [LEN_W-1:0]  cfg_len_in;
   logic [LEN_W-1:0]  pos_len, recv_in;
   logic [NTERM-1:0]  len_mask;
   logic [GRP_BITS-1:0] grp_hits;
   logic              found;
   logic [SEL_W-1:0]  first;
   logic [LEN_W-1:0]  cand_exp;
   logic              scan_done;
   logic [LEN_W-1:0]  k_len;
   logic [BYTE_W-1:0] raw_byte, out_byte;
   logic              beat_last;

   assign string_length = len_ff;
   assign cmd_ready     = state_ff == ST_IDLE;
   assign pop           = cmd_valid && cmd_ready;
   assign mem_we        = pop && cmd.kind == KIND_WRITE;
   assign wr_addr       = cmd.position[IDX_W-1:0];

   always_comb begin
      cfg_len_in = csr_wdata;
      if (csr_wdata == '0) begin
         cfg_len_in = LEN_W'(1);
      end else if (csr_wdata > USABLE_LEN) begin
         cfg_len_in = USABLE_LEN;
      end
   end

   // in-order progress
   always_comb begin
      pos_len = {1'b0, cmd.position};
      recv_in = recv_ff;
      if (cmd.position == '0 ||
          (pos_len == {1'b0, prev_ff} + 1'b1 && recv_ff == pos_len)) begin
         recv_in = pos_len + 1'b1;
      end
   end

   // terminator search, one group of flags per cycle
   always_comb begin
      for (int i = 0; i < NTERM; i++) begin
         len_mask[i] = LEN_W'(i) < len_ff;
      end
      grp_hits = term_ff[int'(grp_ff) * GRP_BITS +: GRP_BITS] &
                 len_mask[int'(grp_ff) * GRP_BITS +: GRP_BITS];
      found = 1'b0;
      first = '0;
      for (int j = GRP_BITS - 1; j >= 0; j--) begin
         if (grp_hits[j]) begin
            found = 1'b1;
            first = SEL_W'(j);
         end
      end
      cand_exp  = found ? LEN_W'({grp_ff, first}) + 1'b1 : len_ff;
      scan_done = found || grp_ff == LAST_GRP;
   end

   always_comb begin
      rd_addr = '0;
      if (state_ff == ST_EMIT) begin
         rd_addr = rsp_tready ? k_ff + 1'b1 : k_ff;
      end
   end

   // output beat
   always_comb begin
      k_len     = LEN_W'(k_ff);
      raw_byte  = valid_ff[k_ff] ? rd_data_ff : NUL;
      out_byte  = (k_len < recv_ff && raw_byte != TERMINATOR && raw_byte != NUL) ?
                  raw_byte : BLANK;
      beat_last = (k_len + 1'b1) == exp_ff;
   end

   assign rsp_tvalid = state_ff == ST_EMIT;
   assign rsp_tdata  = {2'b00, out_byte, POS_W'(k_ff)};
   assign rsp_tlast  = beat_last;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd.char_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= USABLE_LEN;
         recv_ff  <= '0;
         prev_ff  <= '0;
         grp_ff   <= '0;
         k_ff     <= '0;
         valid_ff <= '0;
         term_ff  <= '0;
      end else begin
         if (csr_we) begin
            // growing blanks the newly exposed entries
            for (int i = 0; i < NTERM; i++) begin
               if (LEN_W'(i) >= len_ff && LEN_W'(i) < cfg_len_in) begin
                  term_ff[i] <= 1'b0;
               end
            end
            for (int i = 0; i < USABLE; i++) begin
               if (LEN_W'(i) >= len_ff && LEN_W'(i) < cfg_len_in) begin
                  valid_ff[i] <= 1'b0;
               end
            end
            len_ff <= cfg_len_in;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (cmd.kind == KIND_CLEAR) begin
                     recv_ff <= '0;
                  end else begin
                     valid_ff[wr_addr] <= 1'b1;
                     term_ff[wr_addr]  <= cmd.char_byte == TERMINATOR;
                     recv_ff           <= recv_in;
                     prev_ff           <= cmd.position;
                     grp_ff            <= '0;
                     state_ff          <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  exp_ff   <= cand_exp;
                  state_ff <= (recv_ff >= cand_exp) ? ST_LOAD : ST_IDLE;
               end else begin
                  grp_ff <= grp_ff + 1'b1;
               end
            end
            ST_LOAD: begin
               k_ff     <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_tready) begin
                  if (beat_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### design/rds_text_segment_assembler_top.sv
`timescale 1ns / 1ps
// with the back end idle, a completing write scans groups of 8 terminator flags up to the first
// terminator, else all, then passes a load state before its first beat is presented,
// then one beat per cycle while rsp_tready is high
// clears skip the scan, non-completing writes scan and return to idle; a 2-deep queue takes new beats
// synchronous active-high reset clears control and per-entry valid flags,
// no clearing pass over the store

module rds_text_segment_assembler_top #(
   parameter int MAX_LENGTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,   // string_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // position, char_byte
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_index, out_byte
   output logic        rsp_tlast    // last
);
   import rts_pkg::*;

   localparam int USABLE = (MAX_LENGTH < 64) ? MAX_LENGTH : 64;

   logic             push_valid, push_ready;
   cmd_type          push_cmd;
   logic             cmd_valid, cmd_ready;
   cmd_type          cmd;
   logic [LEN_W-1:0] string_length;

   rts_front u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata[13:0]),
      .req_tuser     (req_tuser),
      .string_length (string_length),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_cmd      (push_cmd)
   );

   rts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (cmd_valid),
      .out_ready (cmd_ready),
      .out_cmd   (cmd)
   );

   rts_back #(
      .USABLE (USABLE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .string_length (string_length),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

### design/rts_checker.sv
`timescale 1ns / 1ps

module rts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   // bytes of a run follow without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[5:0] == $past(rsp_tdata[5:0]) + 6'd1)
      else $error("rsp run index not consecutive");

   // a run ends before anything else is sent
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("rsp beat right after end of run");

   // terminators and nul bytes never leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:6] != 8'h00 && rsp_tdata[13:6] != 8'h0D)
      else $error("rsp byte not substituted");

endmodule

bind rds_text_segment_assembler_top rts_checker u_rts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### tb/rds_text_segment_assembler_top_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
   logic [5:0] idx;
   logic [7:0] data;
   logic       last;
} text_beat_type;

class text_scoreboard;
   logic [7:0]    char_mem [64];
   int unsigned   in_order_len;
   int unsigned   last_pos;
   int unsigned   text_len;
   text_beat_type beat_q [$];
   int            errors;

   function new();
      foreach (char_mem[i]) char_mem[i] = '0;
      in_order_len = 0;
      last_pos     = 0;
      text_len     = 64;
      errors       = 0;
   endfunction

   function int pending();
      return beat_q.size();
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
   endtask

   function void write_length(logic [6:0] value);
      int unsigned n;
      n = value;
      if (n < 1) n = 1;
      if (n > 64) n = 64;
      for (int unsigned i = text_len; i < n; i++) char_mem[i] = rts_pkg::BLANK;
      text_len = n;
   endfunction

   function void note_input(rts_pkg::cmd_type c);
      int unsigned   pos;
      int unsigned   full_len;
      text_beat_type b;
      logic [7:0]    ch;
      if (c.kind == rts_pkg::KIND_CLEAR) begin
         in_order_len = 0;
         return;
      end
      pos = c.position;
      if (pos >= text_len) return;
      char_mem[pos] = c.char_byte;
      if (pos == 0 || (pos == last_pos + 1 && in_order_len == pos)) in_order_len = pos + 1;
      last_pos = pos;
      // string ends at the first terminator within the configured length
      full_len = text_len;
      for (int unsigned i = 0; i < text_len; i++) begin
         if (char_mem[i] == rts_pkg::TERMINATOR) begin
            full_len = i + 1;
            break;
         end
      end
      if (in_order_len < full_len) return;
      for (int unsigned i = 0; i < full_len; i++) begin
         ch     = char_mem[i];
         b.idx  = 6'(i);
         b.data = (in_order_len > i && ch != rts_pkg::TERMINATOR && ch != rts_pkg::NUL) ?
                  ch : rts_pkg::BLANK;
         b.last = (i + 1 == full_len);
         beat_q.push_back(b);
      end
   endfunction

   task check_result(logic [15:0] tdata, logic tlast);
      text_beat_type want;
      if (beat_q.size() == 0) begin
         report($sformatf("unexpected beat index %0d byte %h last %b",
                          tdata[5:0], tdata[13:6], tlast));
         return;
      end
      want = beat_q.pop_front();
      if (tdata[5:0] !== want.idx)
         report($sformatf("out_index %0d, want %0d", tdata[5:0], want.idx));
      if (tdata[13:6] !== want.data)
         report($sformatf("out_byte %h at index %0d, want %h", tdata[13:6], want.idx,
                          want.data));
      if (tlast !== want.last)
         report($sformatf("last %b at index %0d, want %b", tlast, want.idx, want.last));
   endtask
endclass

module rds_text_segment_assembler_top_tb;
   import rts_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 40;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [6:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   text_scoreboard sb = new();
   int             cycles = 0;
   int             sent_items = 0;
   bit             calm = 0;

   rds_text_segment_assembler_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending());
         $display("FAILURE");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // result side back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && hold == 0 && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 16);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic cmd_type mk_cmd(kind_type k, logic [5:0] pos, logic [7:0] char_val);
      cmd_type c;
      c.kind      = k;
      c.position  = pos;
      c.char_byte = char_val;
      return c;
   endfunction

   function automatic logic [7:0] rand_char();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return TERMINATOR;
      if (r == 1) return NUL;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_cmd(input cmd_type c);
      if (sent_items >= 120) calm = 1;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = c.kind;
      req_tdata  = {2'b00, c.char_byte, c.position};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(c);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wr(input logic [5:0] pos, input logic [7:0] char_val);
      send_cmd(mk_cmd(KIND_WRITE, pos, char_val));
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_length(input logic [6:0] value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      sb.write_length(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      logic [6:0] len_cfg;
      int         n;
      int         r;
      bit         big_done;
      bit         paused;
      big_done   = 0;
      paused     = 0;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset length, terminator at the head, repeated position, clear
      wr(6'd63, 8'hA5);
      wr(6'd0, TERMINATOR);
      wr(6'd1, 8'h41);
      wr(6'd1, 8'h42);
      send_cmd(mk_cmd(KIND_CLEAR, 6'd63, 8'hFF));
      wr(6'd0, 8'hFF);

      // zero length taken as one, writes beyond it ignored
      set_length(7'd0);
      wr(6'd0, NUL);
      wr(6'd1, 8'h55);
      wr(6'd63, 8'h00);

      // oversize saturates, then a short string with gaps and rewrites
      set_length(7'd127);
      set_length(7'd4);
      wr(6'd0, 8'h7F);
      wr(6'd2, 8'h80);
      wr(6'd1, 8'h80);
      wr(6'd2, 8'h01);
      wr(6'd3, 8'hFE);
      wr(6'd3, TERMINATOR);
      wr(6'd1, 8'h20);
      send_cmd(mk_cmd(KIND_CLEAR, 6'd0, 8'h00));
      wr(6'd2, 8'h33);
      wr(6'd0, 8'hC3);
      set_length(7'd64);

      while (sent_items < 150) begin
         r = $urandom_range(0, 19);
         if (r == 0 && !big_done) begin
            len_cfg  = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
            big_done = 1;
         end else if (r == 1) begin
            len_cfg = 7'd0;
         end else if (r < 5) begin
            len_cfg = 7'($urandom_range(13, 40));
         end else begin
            len_cfg = 7'($urandom_range(1, 12));
         end
         set_length(len_cfg);
         n = (len_cfg == 0) ? 1 : (len_cfg > 64 ? 64 : len_cfg);
         if ($urandom_range(0, 1) == 0)
            send_cmd(mk_cmd(KIND_CLEAR, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))));
         for (int p = 0; p < n && sent_items < 150; p++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
               send_cmd(mk_cmd(KIND_CLEAR, 6'($urandom), 8'($urandom)));
            else if (r == 1)
               wr(6'($urandom_range(0, 63)), rand_char());
            wr(6'(p), rand_char());
            if (!paused && p == n / 2 && n > 3) begin
               wait_drained();
               paused = 1;
            end
         end
         repeat ($urandom_range(0, 3)) wr(6'($urandom_range(0, n - 1)), rand_char());
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
